FILE: rtl/popi_pkg.sv
// ----------------------------------------------------------------------------
// popi_pkg
// Shared types, constants and the quarter-wave sine generator for the planar
// odometry pose integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package popi_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int DELTA_W = 24;
    localparam int ANGLE_W = 16;
    localparam int TIME_W  = 32;
    localparam int POS_W   = 32;
    localparam int ACC_W   = 48;
    localparam int INC_W   = 34;   // rotated step, Q.16 after rounding

    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_RESET     = 1'b1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [15:0]      t_trig;
    typedef logic signed [INC_W-1:0] t_inc;
    typedef logic signed [ACC_W-1:0] t_acc;

    // Q1.15 magnitude of sin(k * pi/2 / 2^qbits); Q30 Taylor series to x^13.
    // Evaluated at elaboration only.
    function automatic logic [14:0] quarter_sine(input int unsigned k,
                                                 input int unsigned qbits);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          q;
        int              n;
        x    = (longint'(k) * HALF_PI_Q30) >> qbits;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (sum + 16384) >>> 15;
        if (q > 32767) begin
            q = 32767;
        end
        return q[14:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/popi_trig.sv
// ----------------------------------------------------------------------------
// popi_trig
// Sine and cosine of a binary angle from a quarter-wave constant table,
// mirrored into the four quadrants.
// ----------------------------------------------------------------------------
`default_nettype none

module popi_trig import popi_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic [ANGLE_W-1:0] i_heading,
    output t_trig                   o_sin,
    output t_trig                   o_cos
);

    localparam int QB = SINE_TABLE_BITS - 2;
    localparam int QN = 1 << QB;

    logic [14:0] qtab [0:QN];

    for (genvar k = 0; k <= QN; k++) begin : g_qtab
        localparam logic [14:0] VAL = quarter_sine(k, QB);
        assign qtab[k] = VAL;
    end

    function automatic t_trig fold(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0]    quad;
        logic [QB-1:0] r;
        logic [QB:0]   k;
        logic [14:0]   mag;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r    = idx[QB-1:0];
        k    = quad[0] ? ((QB+1)'(QN) - (QB+1)'(r)) : (QB+1)'(r);
        mag  = qtab[k];
        return quad[1] ? -t_trig'({1'b0, mag}) : t_trig'({1'b0, mag});
    endfunction

    logic [SINE_TABLE_BITS-1:0] idx_s;
    logic [SINE_TABLE_BITS-1:0] idx_c;

    assign idx_s = i_heading[ANGLE_W-1 -: SINE_TABLE_BITS];
    assign idx_c = idx_s + SINE_TABLE_BITS'(QN);   // quarter turn ahead

    assign o_sin = fold(idx_s);
    assign o_cos = fold(idx_c);

endmodule

`default_nettype wire

FILE: rtl/popi_rotate.sv
// ----------------------------------------------------------------------------
// popi_rotate
// Rotates the body-frame step into the world frame and rounds the Q.23
// products to Q.16.
// ----------------------------------------------------------------------------
`default_nettype none

module popi_rotate import popi_pkg::*; (
    input  wire logic signed [DELTA_W-1:0] i_dx,
    input  wire logic signed [DELTA_W-1:0] i_dy,
    input  wire t_trig                     i_sin,
    input  wire t_trig                     i_cos,
    output t_inc                           o_inc_x,
    output t_inc                           o_inc_y
);

    localparam int PROD_W = DELTA_W + 16;

    logic signed [PROD_W-1:0] dx_c, dy_s, dx_s, dy_c;
    logic signed [PROD_W:0]   px, py;

    assign dx_c = PROD_W'(i_dx) * PROD_W'(i_cos);
    assign dy_s = PROD_W'(i_dy) * PROD_W'(i_sin);
    assign dx_s = PROD_W'(i_dx) * PROD_W'(i_sin);
    assign dy_c = PROD_W'(i_dy) * PROD_W'(i_cos);

    // +64 then arithmetic shift: round half up from Q.23 to Q.16
    assign px = (PROD_W+1)'(dx_c) - (PROD_W+1)'(dy_s) + (PROD_W+1)'(64);
    assign py = (PROD_W+1)'(dx_s) + (PROD_W+1)'(dy_c) + (PROD_W+1)'(64);

    assign o_inc_x = INC_W'(px >>> 7);
    assign o_inc_y = INC_W'(py >>> 7);

endmodule

`default_nettype wire

FILE: rtl/popi_round.sv
// ----------------------------------------------------------------------------
// popi_round
// Rounds a Q32.16 position to whole millimetres, ties upward, and clamps
// to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module popi_round import popi_pkg::*; (
    input  wire t_acc                    i_acc,
    output logic signed [POS_W-1:0]      o_pos
);

    localparam logic signed [POS_W:0] P_MAX = (POS_W+1)'({1'b0, {(POS_W-1){1'b1}}});
    localparam logic signed [POS_W:0] P_MIN = {2'b11, {(POS_W-1){1'b0}}};

    logic signed [ACC_W:0] biased;
    logic signed [POS_W:0] p;

    assign biased = (ACC_W+1)'(i_acc) + (ACC_W+1)'(32768);
    assign p      = (POS_W+1)'(biased >>> 16);

    always_comb begin
        if (p > P_MAX) begin
            o_pos = P_MAX[POS_W-1:0];
        end else if (p < P_MIN) begin
            o_pos = P_MIN[POS_W-1:0];
        end else begin
            o_pos = p[POS_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/planar_odometry_pose_integrator.sv
// ----------------------------------------------------------------------------
// planar_odometry_pose_integrator
// Dead-reckoning pose integrator: rotates body-frame steps by the current
// heading and accumulates a saturating Q32.16 position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one update transaction: opcode
//   (integrate or reset pose), dx, dy, heading change and a timestamp.
//   Output channel o_valid/i_ready returns one result transaction per input:
//   timestamp, rounded x and y in mm, and the new heading.
//   Four register stages: input/trig, rotate, accumulate, output rounding.
//   A result passes through these stages in that order; one
//   transaction is accepted every cycle, limited only by output stalls.
//   Heading and position are held in the pipeline's own state registers
//   (heading at the input stage, position at the accumulate stage), so
//   consecutive transactions chain without bubbles.
//   When the receiver stalls, stages fill up behind the output register;
//   o_ready drops once all four stages hold a transaction.
//   Reset (i_rst_n low, synchronous) empties the pipeline and zeroes the
//   pose. A reset-pose transaction returns an all-zero result.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_odometry_pose_integrator import popi_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_opcode,
    input  wire logic signed [DELTA_W-1:0]  i_delta_x,
    input  wire logic signed [DELTA_W-1:0]  i_delta_y,
    input  wire logic [ANGLE_W-1:0]         i_delta_heading,
    input  wire logic [TIME_W-1:0]          i_timestamp,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [TIME_W-1:0]               o_time_out,
    output logic signed [POS_W-1:0]         o_pos_x,
    output logic signed [POS_W-1:0]         o_pos_y,
    output logic [ANGLE_W-1:0]              o_heading
);

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // stage enables: a stage loads when it is empty or its successor loads
    logic en1, en2, en3, en4;
    logic in_fire;

    // heading state (input stage)
    logic [ANGLE_W-1:0] r_hd, n_hd;
    t_trig              sin_w, cos_w;

    // stage 1
    logic                      r1_valid;
    logic                      r1_op;
    logic signed [DELTA_W-1:0] r1_dx, r1_dy;
    logic [TIME_W-1:0]         r1_ts;
    logic [ANGLE_W-1:0]        r1_hd;
    t_trig                     r1_sin, r1_cos;

    // stage 2
    logic               r2_valid;
    logic               r2_op;
    logic [TIME_W-1:0]  r2_ts;
    logic [ANGLE_W-1:0] r2_hd;
    t_inc               r2_inc_x, r2_inc_y;
    t_inc               inc_x_w, inc_y_w;

    // stage 3: the position accumulators are this stage's payload
    logic               r3_valid;
    logic [TIME_W-1:0]  r3_ts;
    logic [ANGLE_W-1:0] r3_hd;
    t_acc               r_acc_x, r_acc_y, n_acc_x, n_acc_y;

    // stage 4 (output)
    logic                   r4_valid;
    logic [TIME_W-1:0]      r4_ts;
    logic [ANGLE_W-1:0]     r4_hd;
    logic signed [POS_W-1:0] r4_px, r4_py;
    logic signed [POS_W-1:0] pos_x_w, pos_y_w;

    assign en4     = !r4_valid || i_ready;
    assign en3     = !r3_valid || en4;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_ready = en1;
    assign in_fire = i_valid && en1;

    assign n_hd = (i_opcode == OP_RESET) ? '0 : r_hd + i_delta_heading;

    popi_trig #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_trig (
        .i_heading (r_hd),
        .o_sin     (sin_w),
        .o_cos     (cos_w)
    );

    popi_rotate u_rotate (
        .i_dx    (r1_dx),
        .i_dy    (r1_dy),
        .i_sin   (r1_sin),
        .i_cos   (r1_cos),
        .o_inc_x (inc_x_w),
        .o_inc_y (inc_y_w)
    );

    function automatic t_acc sat_add(input t_acc acc, input t_inc inc);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(inc);
        if (s > (ACC_W+1)'(ACC_MAX)) begin
            return ACC_MAX;
        end else if (s < (ACC_W+1)'(ACC_MIN)) begin
            return ACC_MIN;
        end
        return s[ACC_W-1:0];
    endfunction

    always_comb begin
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        if (r2_valid && en3) begin
            if (r2_op == OP_RESET) begin
                n_acc_x = '0;
                n_acc_y = '0;
            end else begin
                n_acc_x = sat_add(r_acc_x, r2_inc_x);
                n_acc_y = sat_add(r_acc_y, r2_inc_y);
            end
        end
    end

    popi_round u_round_x (
        .i_acc (r_acc_x),
        .o_pos (pos_x_w)
    );

    popi_round u_round_y (
        .i_acc (r_acc_y),
        .o_pos (pos_y_w)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd     <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_hd <= n_hd;
            end
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            if (en1) begin
                r1_valid <= i_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (en4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_op  <= i_opcode;
            r1_dx  <= i_delta_x;
            r1_dy  <= i_delta_y;
            r1_ts  <= (i_opcode == OP_RESET) ? '0 : i_timestamp;
            r1_hd  <= n_hd;
            r1_sin <= sin_w;
            r1_cos <= cos_w;
        end
        if (en2) begin
            r2_op    <= r1_op;
            r2_ts    <= r1_ts;
            r2_hd    <= r1_hd;
            r2_inc_x <= inc_x_w;
            r2_inc_y <= inc_y_w;
        end
        if (en3) begin
            r3_ts <= r2_ts;
            r3_hd <= r2_hd;
        end
        if (en4) begin
            r4_ts <= r3_ts;
            r4_hd <= r3_hd;
            r4_px <= pos_x_w;
            r4_py <= pos_y_w;
        end
    end

    assign o_valid    = r4_valid;
    assign o_time_out = r4_ts;
    assign o_pos_x    = r4_px;
    assign o_pos_y    = r4_py;
    assign o_heading  = r4_hd;

    // a reset-pose transaction entering the accumulate stage clears the pose
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && en3 && r2_op == OP_RESET) |=> (r_acc_x == '0 && r_acc_y == '0))
        else $error("pose not cleared by reset transaction");

    // heading advances by exactly the accepted change
    a_heading_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_opcode == OP_INTEGRATE) |=>
            (r_hd == $past(r_hd + i_delta_heading)))
        else $error("heading state mismatch");

    // accumulated position must hold while its stage waits on a stalled output
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && !en4) |=> ($stable(r_acc_x) && $stable(r_acc_y)))
        else $error("position changed under a stalled transaction");

    // output can only become valid from a filled accumulate stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r4_valid && !r3_valid) |=> !r4_valid)
        else $error("output valid without an upstream transaction");

endmodule

`default_nettype wire
